### rtl/core/jsu_pkg.sv
`default_nettype none
package jsu_pkg;
  localparam int LIMB_COUNT_DEF = 8;
  localparam int LIMB_BITS_DEF  = 32;
  localparam int FIELD_BITS     = 32;

  // Kronecker factor (2/n) for n mod 8, as two's complement 2-bit value
  function automatic logic [1:0] two_factor(input logic [2:0] r);
    logic [1:0] f;
    unique case (r)
      3'd1, 3'd7: f = 2'b01;
      3'd3, 3'd5: f = 2'b11;
      default:    f = 2'b00;
    endcase
    return f;
  endfunction

  function automatic logic [1:0] sign_mul(input logic [1:0] x, input logic [1:0] y);
    logic [1:0] p;
    if (x == 2'b00 || y == 2'b00) p = 2'b00;
    else if (x == y)              p = 2'b01;
    else                          p = 2'b11;
    return p;
  endfunction

  typedef struct packed {
    logic load;      // capture operands
    logic half_a;
    logic half_b;
    logic swap;
    logic sub;
  } jsu_cmd_t;

  typedef struct packed {
    logic a_zero;
    logic a_one;
    logic b_zero;
    logic b_one;
    logic a_even;
    logic b_even;
    logic a_lt_b;
    logic [2:0] a_low;
    logic [2:0] b_low;
  } jsu_stat_t;
endpackage
`default_nettype wire

### rtl/core/jsu_if.sv
`default_nettype none
interface jsu_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] a_limb;
  logic [31:0] b_limb;
  logic        last_limb;
  modport source (output valid, a_limb, b_limb, last_limb, input ready);
  modport sink   (input valid, a_limb, b_limb, last_limb, output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] symbol;
  logic       overflow;
  modport source (output valid, symbol, overflow, input ready);
  modport sink   (input valid, symbol, overflow, output ready);
endinterface
`default_nettype wire

### rtl/core/jsu_datapath.sv
`default_nettype none
module jsu_datapath #(
  parameter int LIMB_COUNT = jsu_pkg::LIMB_COUNT_DEF,
  parameter int LIMB_BITS  = jsu_pkg::LIMB_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          wr_en,
  input  wire logic [$clog2(LIMB_COUNT+1)-1:0] wr_idx,
  input  wire logic [LIMB_BITS-1:0]          wr_a,
  input  wire logic [LIMB_BITS-1:0]          wr_b,
  input  wire logic                          clr,
  input  wire jsu_pkg::jsu_cmd_t             cmd,
  output jsu_pkg::jsu_stat_t                 stat
);
  localparam int W  = LIMB_COUNT * LIMB_BITS;
  localparam int IW = (LIMB_COUNT > 1) ? $clog2(LIMB_COUNT) : 1;

  logic [W-1:0] sa_r, sb_r, a_r, b_r, a_nxt, b_nxt;
  logic [W:0]   diff;
  logic [IW-1:0] idx;

  assign idx  = IW'(wr_idx);
  assign diff = {1'b0, a_r} - {1'b0, b_r};

  // operand stores, cleared on reset and when loaded into the working registers
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      sa_r <= '0;
      sb_r <= '0;
    end else if (wr_en) begin
      sa_r[idx*LIMB_BITS +: LIMB_BITS] <= wr_a;
      sb_r[idx*LIMB_BITS +: LIMB_BITS] <= wr_b;
    end
  end

  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    if (cmd.load) begin
      a_nxt = sa_r;
      b_nxt = sb_r;
    end else if (cmd.swap) begin
      a_nxt = b_r - a_r;
      b_nxt = a_r;
    end else begin
      if (cmd.half_a) a_nxt = a_r >> 1;
      if (cmd.half_b) b_nxt = b_r >> 1;
      if (cmd.sub)    a_nxt = diff[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
  end

  assign stat.a_zero = (a_r == '0);
  assign stat.a_one  = (a_r == W'(1));
  assign stat.b_zero = (b_r == '0);
  assign stat.b_one  = (b_r == W'(1));
  assign stat.a_even = ~a_r[0];
  assign stat.b_even = ~b_r[0];
  assign stat.a_lt_b = diff[W];
  assign stat.a_low  = a_r[2:0];
  assign stat.b_low  = b_r[2:0];
endmodule
`default_nettype wire

### rtl/core/jsu_ctrl.sv
`default_nettype none
module jsu_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire jsu_pkg::jsu_stat_t stat,
  input  wire logic               out_taken,
  output jsu_pkg::jsu_cmd_t       cmd,
  output logic                    busy,
  output logic                    done_r,
  output logic [1:0]              sym_r
);
  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_CHECK, S_STRIPB, S_LOOP, S_STRIPA, S_SWAP, S_DONE}
    state_t;
  state_t state_r;
  logic [1:0] k_r;
  logic       v_r;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_LOAD:   cmd.load = 1'b1;
      S_STRIPB: cmd.half_b = stat.b_even;
      S_STRIPA: cmd.half_a = stat.a_even;
      S_SWAP:   begin
        cmd.swap = stat.a_lt_b;
        cmd.sub  = ~stat.a_lt_b;
      end
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
      sym_r   <= 2'b00;
      k_r     <= 2'b01;
      v_r     <= 1'b0;
    end else begin
      unique case (state_r)
        // start moves to S_LOAD, so the final limb is already in the stores when S_LOAD loads
        S_IDLE: if (start) state_r <= S_LOAD;
        S_LOAD: state_r <= S_CHECK;
        S_CHECK: begin
          v_r <= 1'b0;
          if (stat.b_zero) begin
            sym_r <= stat.a_one ? 2'b01 : 2'b00;
            state_r <= S_DONE;
          end else if (stat.a_even && stat.b_even) begin
            sym_r <= 2'b00;
            state_r <= S_DONE;
          end else state_r <= S_STRIPB;
        end
        S_STRIPB: if (stat.b_even) v_r <= ~v_r;
          else begin
            k_r <= v_r ? jsu_pkg::two_factor(stat.a_low) : 2'b01;
            state_r <= S_LOOP;
          end
        S_LOOP: begin
          v_r <= 1'b0;
          if (stat.a_zero) begin
            sym_r <= stat.b_one ? k_r : 2'b00;
            state_r <= S_DONE;
          end else state_r <= S_STRIPA;
        end
        S_STRIPA: if (stat.a_even) v_r <= ~v_r;
          else begin
            if (v_r) k_r <= jsu_pkg::sign_mul(k_r, jsu_pkg::two_factor(stat.b_low));
            state_r <= S_SWAP;
          end
        S_SWAP: begin
          // swap gives new a = b - a and new b = a: flip when a and b are both 3 mod 4
          if (stat.a_lt_b && stat.a_low[1] && stat.b_low[1])
            k_r <= jsu_pkg::sign_mul(k_r, 2'b11);
          state_r <= S_LOOP;
        end
        S_DONE: begin
          done_r <= 1'b1;
          if (done_r && out_taken) begin
            done_r  <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/core/jacobi_symbol_unit.sv
// Operation: limbs load at one per cycle while the unit is idle; a last-limb request
// then loads the working registers and checks them (done when b is zero or both are even),
// strips twos from b, then loops on stripping a and a swap or subtract until a is zero.
// Throughput: one operand pair at a time; input stalls until the result is taken.
// Reset (rst_n, synchronous): clears stores, limb count, overflow and controller.
`default_nettype none
module jacobi_symbol_unit #(
  parameter int LIMB_COUNT = jsu_pkg::LIMB_COUNT_DEF,
  parameter int LIMB_BITS  = jsu_pkg::LIMB_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  jsu_in_if.sink   in_ch,
  jsu_out_if.source out_ch
);
  localparam int CW = $clog2(LIMB_COUNT + 1);
  logic [CW-1:0] cnt_r;
  logic ovf_r, busy, done, acc, start, wr_en;
  logic [1:0] sym;
  jsu_pkg::jsu_cmd_t  cmd;
  jsu_pkg::jsu_stat_t stat;
  logic [LIMB_BITS-1:0] wa, wb;

  assign in_ch.ready = ~busy;
  assign acc   = in_ch.valid & in_ch.ready;
  assign wr_en = acc && (cnt_r < CW'(LIMB_COUNT));
  assign start = acc && in_ch.last_limb;

  always_comb begin
    wa = '0;
    wb = '0;
    for (int i = 0; i < LIMB_BITS && i < jsu_pkg::FIELD_BITS; i++) begin
      wa[i] = in_ch.a_limb[i];
      wb[i] = in_ch.b_limb[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (out_ch.valid && out_ch.ready)) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else if (acc) begin
      if (wr_en) cnt_r <= cnt_r + CW'(1);
      else       ovf_r <= 1'b1;
    end
  end

  // stores drop their contents as they are loaded into the working registers
  jsu_datapath #(.LIMB_COUNT(LIMB_COUNT), .LIMB_BITS(LIMB_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .wr_en(wr_en), .wr_idx(cnt_r), .wr_a(wa), .wr_b(wb),
    .clr(cmd.load), .cmd(cmd), .stat(stat)
  );

  jsu_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .stat(stat),
    .out_taken(out_ch.ready), .cmd(cmd), .busy(busy), .done_r(done), .sym_r(sym)
  );

  assign out_ch.valid    = done;
  assign out_ch.symbol   = sym;
  assign out_ch.overflow = ovf_r;
endmodule
`default_nettype wire
